// ----- design/selection_sort_engine_macros.svh -----
// Assertion macros shared by the selection sort engine RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef SELECTION_SORT_ENGINE_MACROS_SVH
`define SELECTION_SORT_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sse_pkg.sv -----
// Package for the selection sort engine: store geometry, field widths
// and the controller state type. No dependencies.
package sse_pkg;

    localparam int DEPTH   = 64;
    localparam int VALUE_W = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [CNT_W-1:0]          count_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SWAP_LO,
        ST_SWAP_HI,
        ST_EMIT
    } state_t;

endpackage

// ----- design/sse_if.sv -----
// Valid/ready channel interfaces for the selection sort engine:
// the element feed and the sorted result stream. Depends on sse_pkg.
interface sse_in_if;
    import sse_pkg::*;

    logic   valid;
    logic   ready;
    value_t value_in;
    logic   is_last;

    modport source (output valid, output value_in, output is_last, input ready);
    modport sink   (input valid, input value_in, input is_last, output ready);
endinterface

interface sse_out_if;
    import sse_pkg::*;

    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   last_out;
    logic   dropped;

    modport source (output valid, output sorted_value, output last_out, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input dropped,
                    output ready);
endinterface

// ----- design/selection_sort_engine.sv -----
// Selection sort engine top level: element store, scan/swap controller
// and result register. Depends on sse_pkg, sse_if.sv and the macros header.
//
// Elements are accepted one per cycle into a 64-entry store; a transaction
// with is_last closes the set, and elements beyond the store depth are
// discarded and flag every result of that set as dropped. While sorting and
// emitting, feed.ready is low. Each sort pass reads the remaining entries one
// per cycle through the store's single read port, drains the last read and
// closes the scan, then writes the swap through the store's single write port
// in ST_SWAP_LO and ST_SWAP_HI. Each result is read from the store, then
// registered; the next read waits until that result is registered and the
// result register is empty or taken by the sink.
`include "selection_sort_engine_macros.svh"

module selection_sort_engine
(
    input  logic             clk,
    input  logic             rst_n,
    sse_in_if.sink           feed,
    sse_out_if.source        result
);
    import sse_pkg::*;

    value_t element_store [DEPTH];
    value_t mem_q;

    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    value_t wr_data;

    state_t state_reg,    state_next;
    count_t count_reg,    count_next;
    logic   overflow_reg, overflow_next;
    addr_t  pos_reg,      pos_next;
    count_t j_reg,        j_next;
    logic   rd_pend_reg,  rd_pend_next;
    addr_t  rd_idx_reg,   rd_idx_next;
    addr_t  best_idx_reg, best_idx_next;
    value_t best_val_reg, best_val_next;
    value_t pos_val_reg,  pos_val_next;
    logic   out_valid_reg, out_valid_next;
    value_t out_val_reg,  out_val_next;
    logic   out_last_reg, out_last_next;
    logic   out_drop_reg, out_drop_next;

    logic   feed_acc;
    count_t count_grow;
    count_t pos_inc;
    logic   rd_is_last;

    assign feed.ready          = (state_reg == ST_LOAD);
    assign feed_acc            = feed.valid && feed.ready;
    assign result.valid        = out_valid_reg;
    assign result.sorted_value = out_val_reg;
    assign result.last_out     = out_last_reg;
    assign result.dropped      = out_drop_reg;

    assign pos_inc    = {1'b0, pos_reg} + CNT_ONE;
    assign rd_is_last = ({1'b0, rd_idx_reg} + CNT_ONE) == count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            element_store[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= element_store[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        rd_idx_next    = rd_idx_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        pos_val_next   = pos_val_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;
        count_grow     = count_reg;
        rd_en          = 1'b0;
        rd_addr        = j_reg[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = count_reg[ADDR_W-1:0];
        wr_data        = feed.value_in;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (feed_acc)
                begin
                    if (count_reg < DEPTH_C)
                    begin
                        wr_en      = 1'b1;
                        count_grow = count_reg + CNT_ONE;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    count_next = count_grow;
                    if (feed.is_last)
                    begin
                        pos_next = '0;
                        j_next   = '0;
                        if (count_grow < CNT_TWO)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (j_reg < count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = j_reg[ADDR_W-1:0];
                    j_next      = j_reg + CNT_ONE;
                end
                if (rd_pend_reg)
                begin
                    if (rd_idx_reg == pos_reg)
                    begin
                        best_idx_next = pos_reg;
                        best_val_next = mem_q;
                        pos_val_next  = mem_q;
                    end
                    else if (best_val_reg > mem_q)
                    begin
                        best_idx_next = rd_idx_reg;
                        best_val_next = mem_q;
                    end
                end
                if (j_reg == count_reg && !rd_pend_reg)
                begin
                    state_next = ST_SWAP_LO;
                end
            end
            ST_SWAP_LO:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = best_val_reg;
                state_next = ST_SWAP_HI;
            end
            ST_SWAP_HI:
            begin
                wr_en    = 1'b1;
                wr_addr  = best_idx_reg;
                wr_data  = pos_val_reg;
                pos_next = pos_inc[ADDR_W-1:0];
                if ((pos_inc + CNT_ONE) < count_reg)
                begin
                    j_next     = pos_inc;
                    state_next = ST_SCAN;
                end
                else
                begin
                    j_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (rd_pend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = mem_q;
                    out_last_next  = rd_is_last;
                    out_drop_next  = overflow_reg;
                    if (rd_is_last)
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = ST_LOAD;
                    end
                end
                else if (j_reg < count_reg && (!out_valid_reg || result.ready))
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = j_reg[ADDR_W-1:0];
                    j_next      = j_reg + CNT_ONE;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        rd_pend_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            pos_reg       <= '0;
            j_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            pos_reg       <= pos_next;
            j_reg         <= j_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        pos_val_reg  <= pos_val_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    `SSE_ASSERT_NOW(a_emit_slot_free, state_reg == ST_EMIT && rd_pend_reg, !out_valid_reg, "result register overwritten")
    `SSE_ASSERT_NOW(a_write_states, wr_en, state_reg == ST_LOAD || state_reg == ST_SWAP_LO || state_reg == ST_SWAP_HI, "store written outside load or swap")
    `SSE_ASSERT_NOW(a_best_in_range, state_reg == ST_SWAP_LO, (best_idx_reg >= pos_reg && ({1'b0, best_idx_reg} < count_reg)), "selected index outside unsorted range")
    `SSE_ASSERT_NEXT(a_set_closed, state_reg == ST_EMIT && rd_pend_reg && rd_is_last, state_reg == ST_LOAD && count_reg == '0 && !overflow_reg, "set not closed after last result")

endmodule
